### rtl/core/tpc_pkg.sv
// Shared types and constants for the two-button press classifier.
`timescale 1ns / 1ps

package tpc_pkg;

    typedef enum logic [2:0] {
        EV_NONE       = 3'd0,
        EV_SHORT_UP   = 3'd1,
        EV_LONG_UP    = 3'd2,
        EV_SHORT_DOWN = 3'd3,
        EV_LONG_DOWN  = 3'd4,
        EV_BOTH       = 3'd5
    } press_event_t;

    typedef enum logic {
        CFG_LONG_HOLD_MS     = 1'b0,
        CFG_EXPANDER_PRESENT = 1'b1
    } cfg_index_t;

    localparam int unsigned PORT_W     = 8;
    localparam int unsigned NOW_W      = 32;
    localparam int unsigned HOLD_W     = 16;
    localparam int unsigned UP_BIT     = 0;
    localparam int unsigned DOWN_BIT   = 4;
    localparam logic [HOLD_W-1:0] DEBOUNCE_MS   = 16'd50;
    localparam logic [HOLD_W-1:0] LONG_HOLD_RST = 16'd1000;

endpackage

### rtl/core/two_button_press_classifier.sv
// Top level of the two-button press classifier: state, classification and result register.
`timescale 1ns / 1ps

// Takes one sample per cycle while not stalled (port byte plus millisecond timestamp) and
// returns exactly one press event per sample, in order. Each sample is classified in the
// cycle it is accepted (a TIME_BITS-wide subtract from the kept press start and two compares
// against the debounce and long-hold limits) and the event lands in a result register; a new
// sample is accepted whenever the result register is empty or being drained. Only the low
// min(TIME_BITS, 32) timestamp bits are used and elapsed time wraps modulo 2^TIME_BITS.
// Configuration writes take effect at the next clock edge.
module two_button_press_classifier #(
    parameter int unsigned TIME_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_port_byte,
    input  logic [31:0] s_now_ms,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_press_event
);

    localparam int unsigned NOW_USE = (TIME_BITS < tpc_pkg::NOW_W) ? TIME_BITS : tpc_pkg::NOW_W;

    logic [tpc_pkg::HOLD_W-1:0] long_hold_ms_reg;
    logic                       expander_present_reg;

    logic                 up_was_pressed_reg,   up_was_pressed_next;
    logic                 down_was_pressed_reg, down_was_pressed_next;
    logic                 both_latched_reg,     both_latched_next;
    logic [TIME_BITS-1:0] up_press_start_reg,   up_press_start_next;
    logic [TIME_BITS-1:0] down_press_start_reg, down_press_start_next;

    logic                  m_valid_reg;
    tpc_pkg::press_event_t m_press_event_reg, m_press_event_next;

    logic                 s_accept;
    logic                 up_now, down_now;
    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] dur;
    logic [TIME_BITS-1:0] hold_ext;
    logic [TIME_BITS-1:0] debounce_ext;
    logic                 both_ev;
    logic                 latched_mid;
    logic                 up_rel, down_rel;

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_press_event = m_press_event_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_hold_ms_reg     <= tpc_pkg::LONG_HOLD_RST;
            expander_present_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (tpc_pkg::cfg_index_t'(cfg_addr))
                tpc_pkg::CFG_LONG_HOLD_MS:     long_hold_ms_reg     <= cfg_wdata;
                tpc_pkg::CFG_EXPANDER_PRESENT: expander_present_reg <= cfg_wdata[0];
                default:                       long_hold_ms_reg     <= long_hold_ms_reg;
            endcase
        end
    end

    assign now_t        = TIME_BITS'(s_now_ms[NOW_USE-1:0]);
    assign hold_ext     = TIME_BITS'(long_hold_ms_reg);
    assign debounce_ext = TIME_BITS'(tpc_pkg::DEBOUNCE_MS);
    assign up_now   = expander_present_reg && !s_port_byte[tpc_pkg::UP_BIT];
    assign down_now = expander_present_reg && !s_port_byte[tpc_pkg::DOWN_BIT];

    assign both_ev     = (!down_now || !up_now) && down_was_pressed_reg && up_was_pressed_reg;
    assign latched_mid = both_latched_reg || both_ev;
    assign up_rel   = !up_now && up_was_pressed_reg && !down_now && !latched_mid;
    assign down_rel = !down_now && down_was_pressed_reg && !up_now && !latched_mid;
    assign dur = down_rel ? (now_t - down_press_start_reg) : (now_t - up_press_start_reg);

    always_comb begin
        up_press_start_next   = up_press_start_reg;
        down_press_start_next = down_press_start_reg;
        if (up_now && !up_was_pressed_reg) begin
            up_press_start_next = now_t;
        end
        if (down_now && !down_was_pressed_reg) begin
            down_press_start_next = now_t;
        end
        up_was_pressed_next   = up_now;
        down_was_pressed_next = down_now;
        both_latched_next     = (!down_now && !up_now) ? 1'b0 : latched_mid;

        m_press_event_next = both_ev ? tpc_pkg::EV_BOTH : tpc_pkg::EV_NONE;
        priority if (down_rel && (dur > debounce_ext)) begin
            m_press_event_next = (dur < hold_ext) ? tpc_pkg::EV_SHORT_DOWN
                                                  : tpc_pkg::EV_LONG_DOWN;
        end else if (up_rel && (dur > debounce_ext)) begin
            m_press_event_next = (dur < hold_ext) ? tpc_pkg::EV_SHORT_UP
                                                  : tpc_pkg::EV_LONG_UP;
        end else begin
            m_press_event_next = m_press_event_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            up_was_pressed_reg   <= 1'b0;
            down_was_pressed_reg <= 1'b0;
            both_latched_reg     <= 1'b0;
            up_press_start_reg   <= '0;
            down_press_start_reg <= '0;
            m_valid_reg          <= 1'b0;
        end else begin
            if (s_accept) begin
                up_was_pressed_reg   <= up_was_pressed_next;
                down_was_pressed_reg <= down_was_pressed_next;
                both_latched_reg     <= both_latched_next;
                up_press_start_reg   <= up_press_start_next;
                down_press_start_reg <= down_press_start_next;
                m_valid_reg          <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_press_event_reg <= m_press_event_next;
        end
    end

    a_latched_blocks_single: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && both_latched_reg |=>
            (m_press_event == tpc_pkg::EV_NONE) || (m_press_event == tpc_pkg::EV_BOTH))
        else $error("single release reported while both-pressed latch set");

    a_absent_releases: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && !expander_present_reg && !cfg_wr_en |=>
            !up_was_pressed_reg && !down_was_pressed_reg && !both_latched_reg)
        else $error("button state kept while expander absent");

    a_idle_no_event: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && !up_was_pressed_reg && !down_was_pressed_reg |=>
            m_press_event == tpc_pkg::EV_NONE)
        else $error("event reported without a prior press");

    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_valid)
        else $error("accepted transaction produced no result");

endmodule

### dv/tb_two_button_press_classifier.sv
// Testbench for the two-button press classifier: directed and random samples against a predictor.
`timescale 1ns / 1ps

module tb_two_button_press_classifier;

    localparam int unsigned CYCLE_LIMIT = 400000;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_addr;
    logic [15:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_port_byte;
    logic [31:0] s_now_ms;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_press_event;

    logic [15:0] hold_ms;
    logic        present;
    logic        up_held;
    logic        down_held;
    logic        pair_latched;
    logic [31:0] up_since;
    logic [31:0] down_since;

    tpc_pkg::press_event_t event_q[$];
    int unsigned  error_count;
    int unsigned  sample_count;
    int unsigned  cycle_count;
    int unsigned  send_idle_pct;
    int unsigned  recv_idle_pct;
    logic [31:0]  clock_ms;

    two_button_press_classifier #(
        .TIME_BITS(32)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_port_byte   (s_port_byte),
        .s_now_ms      (s_now_ms),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_press_event (m_press_event)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= 50) begin
            $display("[%0t] MISMATCH: %s", $time, what);
        end
    endtask

    always @(posedge aclk) begin : result_check
        tpc_pkg::press_event_t expected;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (event_q.size() == 0) begin
                report_mismatch($sformatf("unexpected press_event %0d", m_press_event));
            end else begin
                expected = event_q.pop_front();
                if (m_press_event !== expected) begin
                    report_mismatch($sformatf("press_event %0d, expected %0d (%s)",
                                              m_press_event, expected, expected.name()));
                end
            end
        end
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    function automatic tpc_pkg::press_event_t grade_release(
        input logic [31:0] dur,
        input tpc_pkg::press_event_t short_ev,
        input tpc_pkg::press_event_t long_ev,
        input tpc_pkg::press_event_t prev
    );
        if (dur > tpc_pkg::DEBOUNCE_MS) begin
            return (dur < hold_ms) ? short_ev : long_ev;
        end
        return prev;
    endfunction

    function automatic tpc_pkg::press_event_t predict_event(input logic [7:0] port,
                                                            input logic [31:0] now);
        logic up;
        logic down;
        tpc_pkg::press_event_t ev;
        up = present && !port[tpc_pkg::UP_BIT];
        down = present && !port[tpc_pkg::DOWN_BIT];
        ev = tpc_pkg::EV_NONE;
        if (up && !up_held) begin
            up_since = now;
        end
        if (down && !down_held) begin
            down_since = now;
        end
        if ((!down || !up) && down_held && up_held) begin
            pair_latched = 1'b1;
            ev = tpc_pkg::EV_BOTH;
        end
        if (!up && up_held && !down && !pair_latched) begin
            ev = grade_release(now - up_since, tpc_pkg::EV_SHORT_UP, tpc_pkg::EV_LONG_UP, ev);
        end
        if (!down && down_held && !up && !pair_latched) begin
            ev = grade_release(now - down_since, tpc_pkg::EV_SHORT_DOWN,
                               tpc_pkg::EV_LONG_DOWN, ev);
        end
        if (!down && !up) begin
            pair_latched = 1'b0;
        end
        up_held = up;
        down_held = down;
        return ev;
    endfunction

    task automatic send_sample(input logic [7:0] port, input logic [31:0] now);
        s_valid <= 1'b1;
        s_port_byte <= port;
        s_now_ms <= now;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        event_q.push_back(predict_event(port, now));
        sample_count++;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic wait_results_done();
        s_valid <= 1'b0;
        while (event_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input tpc_pkg::cfg_index_t idx, input logic [15:0] value);
        wait_results_done();
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            tpc_pkg::CFG_LONG_HOLD_MS:     hold_ms = value;
            tpc_pkg::CFG_EXPANDER_PRESENT: present = value[0];
        endcase
    endtask

    task automatic tap(input logic [7:0] pressed, input logic [31:0] start,
                       input logic [31:0] dur);
        send_sample(pressed, start);
        send_sample(8'hFF, start + dur);
    endtask

    function automatic logic [7:0] port_of(input logic up_pressed, input logic down_pressed);
        logic [7:0] b;
        b = 8'($urandom);
        b[tpc_pkg::UP_BIT] = !up_pressed;
        b[tpc_pkg::DOWN_BIT] = !down_pressed;
        return b;
    endfunction

    function automatic logic [31:0] pick_duration();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 100);
            1:       return 32'(hold_ms) + $urandom_range(0, 6) - 3;
            2:       return $urandom_range(0, 2 * hold_ms + 100);
            3:       return $urandom;
            4:       return $urandom_range(45, 55);
            default: return $urandom_range(0, 3000);
        endcase
    endfunction

    task automatic run_press_scenario();
        int unsigned kind;
        int unsigned holds;
        logic        which;
        logic        keep;
        kind = $urandom_range(0, 9);
        which = 1'($urandom_range(0, 1));
        keep = 1'($urandom_range(0, 1));
        clock_ms += $urandom_range(0, 5000);
        if ($urandom_range(0, 19) == 0) begin
            clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
        end
        case (kind)
            0, 1, 2, 3, 4: begin
                send_sample(port_of(!which, which), clock_ms);
                holds = $urandom_range(0, 2);
                repeat (holds) send_sample(port_of(!which, which),
                                           clock_ms + $urandom_range(0, 40));
                clock_ms += pick_duration();
                send_sample(port_of(1'b0, 1'b0), clock_ms);
            end
            5, 6: begin
                send_sample(port_of(!which, which), clock_ms);
                clock_ms += $urandom_range(0, 100);
                send_sample(port_of(1'b1, 1'b1), clock_ms);
                clock_ms += pick_duration();
                if ($urandom_range(0, 2) == 0) begin
                    send_sample(port_of(1'b0, 1'b0), clock_ms);
                end else begin
                    send_sample(port_of(!keep, keep), clock_ms);
                    clock_ms += pick_duration();
                    send_sample(port_of(1'b0, 1'b0), clock_ms);
                end
            end
            7: begin
                send_sample(port_of(!which, which), clock_ms);
                clock_ms += pick_duration();
                send_sample(port_of(which, !which), clock_ms);
                clock_ms += pick_duration();
                send_sample(port_of(1'b0, 1'b0), clock_ms);
            end
            default: begin
                repeat ($urandom_range(1, 6)) begin
                    send_sample(8'($urandom), $urandom_range(0, 1) ?
                                $urandom : clock_ms + $urandom_range(0, 100));
                end
            end
        endcase
    endtask

    task automatic retune_config();
        logic [15:0] hold_pick;
        case ($urandom_range(0, 5))
            0:       hold_pick = '0;
            1:       hold_pick = 16'hFFFF;
            2:       hold_pick = tpc_pkg::DEBOUNCE_MS + 16'($urandom_range(0, 1));
            3:       hold_pick = tpc_pkg::LONG_HOLD_RST;
            default: hold_pick = 16'($urandom);
        endcase
        write_reg(tpc_pkg::CFG_LONG_HOLD_MS, hold_pick);
        write_reg(tpc_pkg::CFG_EXPANDER_PRESENT,
                  {15'($urandom), ($urandom_range(0, 4) != 0)});
    endtask

    task automatic test_expander_absent();
        tap(8'h00, 32'd0, 32'd2000);
        write_reg(tpc_pkg::CFG_EXPANDER_PRESENT, 16'h0001);
    endtask

    task automatic test_single_releases();
        tap(8'hFE, 32'd100, 32'd300);
        tap(8'hFE, 32'd1000, 32'd1000);
        tap(8'hFE, 32'd3000, 32'd50);
        tap(8'hFE, 32'd3100, 32'd51);
        tap(8'hEF, 32'd5000, 32'd1000);
        tap(8'hEF, 32'd7000, 32'd200);
    endtask

    task automatic test_both_pressed();
        send_sample(8'hEE, 32'd9000);
        send_sample(8'hEF, 32'd10000);
        send_sample(8'hFF, 32'd10100);
        send_sample(8'h00, 32'd11000);
        send_sample(8'hFF, 32'd11020);
    endtask

    task automatic test_time_wrap();
        tap(8'hFE, 32'hFFFF_FF00, 32'd512);
    endtask

    task automatic test_hold_extremes();
        write_reg(tpc_pkg::CFG_LONG_HOLD_MS, 16'h0000);
        tap(8'hEF, 32'd100, 32'd51);
        write_reg(tpc_pkg::CFG_LONG_HOLD_MS, 16'hFFFF);
        tap(8'hFE, 32'd1000, 32'd65534);
        tap(8'hFE, 32'd200000, 32'd65535);
        write_reg(tpc_pkg::CFG_LONG_HOLD_MS, tpc_pkg::LONG_HOLD_RST);
    endtask

    task automatic test_random_traffic(input int unsigned count, input int unsigned s_idle,
                                       input int unsigned r_idle);
        int unsigned stop_at;
        int unsigned next_retune;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        stop_at = sample_count + count;
        next_retune = sample_count + $urandom_range(100, 250);
        while (sample_count < stop_at) begin
            if (sample_count >= next_retune) begin
                retune_config();
                next_retune = sample_count + $urandom_range(100, 250);
            end
            run_press_scenario();
        end
    endtask

    initial begin
        aresetn <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_addr <= tpc_pkg::CFG_LONG_HOLD_MS;
        cfg_wdata <= '0;
        s_valid <= 1'b0;
        s_port_byte <= '0;
        s_now_ms <= '0;
        hold_ms = tpc_pkg::LONG_HOLD_RST;
        present = 1'b0;
        up_held = 1'b0;
        down_held = 1'b0;
        pair_latched = 1'b0;
        up_since = '0;
        down_since = '0;
        error_count = 0;
        sample_count = 0;
        cycle_count = 0;
        send_idle_pct = 38;
        recv_idle_pct = 61;
        clock_ms = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_expander_absent();
        test_single_releases();
        test_both_pressed();
        test_time_wrap();
        test_hold_extremes();
        test_random_traffic(541, 38, 61);
        test_random_traffic(541, 61, 38);
        test_random_traffic(542, 0, 0);

        wait_results_done();
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
